// ----- hdl/tms_pkg.sv -----
// package for the triangle midpoint subdivider
// holds transaction types, command codes and sequencer states
// no dependencies
package tms_pkg;

  localparam int IDX_W = 12;
  localparam int CRD_W = 16;
  localparam int CNT_W = 13;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRI   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  // reserved code, ignored by the block
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic KIND_VERT = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  localparam logic [CNT_W-1:0] IVC_RESET = 13'd12;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [IDX_W-1:0]        vert_a;
    logic [IDX_W-1:0]        vert_b;
    logic [IDX_W-1:0]        vert_c;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic                    out_kind;
    logic [IDX_W-1:0]        new_index;
    logic signed [CRD_W-1:0] new_x;
    logic signed [CRD_W-1:0] new_y;
    logic signed [CRD_W-1:0] new_z;
    logic [IDX_W-1:0]        tri_first;
    logic [IDX_W-1:0]        tri_second;
    logic [IDX_W-1:0]        tri_third;
    logic                    store_full;
    logic                    last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_START
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } q_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] mid;
  } edge_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_NEW,
    ST_RD_HI,
    ST_SUM,
    ST_EMIT_V,
    ST_NEXT,
    ST_EMIT_T
  } state_t;

endpackage

// ----- hdl/tms_front.sv -----
// front end: accepts input transactions, classifies them, two-entry queue
// depends on tms_pkg
module tms_front
  import tms_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     pop
);

  q_item_t    qmem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  op_t        op;
  logic       push;

  // classify the command; unknown codes are dropped
  always_comb begin
    op   = OP_LOAD;
    keep = 1'b0;
    unique case (in_data.cmd)
      CMD_LOAD: begin
        op   = OP_LOAD;
        keep = 1'b1;
      end
      CMD_TRI: begin
        op   = OP_TRI;
        keep = 1'b1;
      end
      CMD_START: begin
        op   = OP_START;
        keep = 1'b1;
      end
      default: begin
        op   = OP_LOAD;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_item   = qmem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= '{op: op, a: in_data.vert_a, b: in_data.vert_b, c: in_data.vert_c,
                        x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ----- hdl/tms_back.sv -----
// back end: vertex store, edge map search, midpoint creation, output register
// depends on tms_pkg
module tms_back
  import tms_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] ivc,
  input  logic             q_valid,
  input  q_item_t          q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int VDEPTH = (MAX_VERTICES > 4096) ? 4096 : MAX_VERTICES;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW    = $clog2(MAX_EDGES + 1);
  localparam logic [CNT_W-1:0] VLIM = CNT_W'(VDEPTH);
  localparam logic [ECW-1:0]   ELIM = ECW'(MAX_EDGES);

  vtx_t  vmem [VDEPTH];
  edge_t emem [MAX_EDGES];

  state_t           state, state_next;
  q_item_t          cur;
  logic [1:0]       esel;
  logic [1:0]       tsel;
  logic [ECW-1:0]   srch;
  logic [ECW-1:0]   edge_count;
  logic [CNT_W-1:0] next_vertex;
  logic [IDX_W-1:0] mid [3];
  logic             full;
  vtx_t             plo;
  vtx_t             nmid;
  vtx_t             vrd;
  logic             vrd_ok;
  edge_t            erd;

  logic [IDX_W-1:0] p, q, lo, hi;
  logic             match, overflow, out_free, out_load;
  logic             v_we, v_rok;
  logic [VAW-1:0]   v_waddr, v_raddr;
  vtx_t             v_wdata, vhi, msum;
  logic             e_we;
  logic             load_ok;
  logic signed [CRD_W:0] sx, sy, sz;
  logic [IDX_W-1:0] t_first, t_second, t_third;

  // edge endpoints, smaller index first
  always_comb begin
    case (esel)
      2'd1:    begin p = cur.b; q = cur.c; end
      2'd2:    begin p = cur.c; q = cur.a; end
      default: begin p = cur.a; q = cur.b; end
    endcase
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
  end

  assign match    = (erd.lo == lo) && (erd.hi == hi);
  assign overflow = (next_vertex >= VLIM) || (edge_count >= ELIM);
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state == ST_EMIT_V || state == ST_EMIT_T);
  assign load_ok  = ({1'b0, q_item.a} < VLIM);

  // midpoint: arithmetic shift of the signed sum
  assign vhi = vrd_ok ? vrd : '0;
  assign sx  = {plo.x[CRD_W-1], plo.x} + {vhi.x[CRD_W-1], vhi.x};
  assign sy  = {plo.y[CRD_W-1], plo.y} + {vhi.y[CRD_W-1], vhi.y};
  assign sz  = {plo.z[CRD_W-1], plo.z} + {vhi.z[CRD_W-1], vhi.z};
  assign msum = '{x: sx[CRD_W:1], y: sy[CRD_W:1], z: sz[CRD_W:1]};

  // child triangle corners in output order
  always_comb begin
    case (tsel)
      2'd0:    begin t_first = cur.a;  t_second = mid[0]; t_third = mid[2]; end
      2'd1:    begin t_first = cur.b;  t_second = mid[1]; t_third = mid[0]; end
      2'd2:    begin t_first = cur.c;  t_second = mid[2]; t_third = mid[1]; end
      default: begin t_first = mid[0]; t_second = mid[1]; t_third = mid[2]; end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (q_valid && q_item.op == OP_TRI) state_next = ST_SRCH_RD;
      ST_SRCH_RD:  state_next = (srch >= edge_count) ? ST_NEW : ST_SRCH_CMP;
      ST_SRCH_CMP: state_next = match ? ST_NEXT : ST_SRCH_RD;
      ST_NEW:      state_next = overflow ? ST_NEXT : ST_RD_HI;
      ST_RD_HI:    state_next = ST_SUM;
      ST_SUM:      state_next = ST_EMIT_V;
      ST_EMIT_V:   if (out_free) state_next = ST_NEXT;
      ST_NEXT:     state_next = (esel == 2'd2) ? ST_EMIT_T : ST_SRCH_RD;
      ST_EMIT_T:   if (out_free && tsel == 2'd3) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    pop     = 1'b0;
    v_we    = 1'b0;
    v_waddr = next_vertex[VAW-1:0];
    v_wdata = msum;
    v_raddr = lo[VAW-1:0];
    v_rok   = ({1'b0, lo} < VLIM);
    e_we    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop     = q_valid;
        v_we    = q_valid && q_item.op == OP_LOAD && load_ok;
        v_waddr = q_item.a[VAW-1:0];
        v_wdata = '{x: q_item.x, y: q_item.y, z: q_item.z};
      end
      ST_RD_HI: begin
        v_raddr = hi[VAW-1:0];
        v_rok   = ({1'b0, hi} < VLIM);
      end
      ST_SUM: begin
        v_we = 1'b1;
        e_we = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vrd    <= vmem[v_raddr];
    vrd_ok <= v_rok;
  end

  // edge map
  always_ff @(posedge clk) begin
    if (e_we) emem[edge_count[EAW-1:0]] <= '{lo: lo, hi: hi, mid: next_vertex[IDX_W-1:0]};
    erd <= emem[srch[EAW-1:0]];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      edge_count  <= '0;
      next_vertex <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur  <= q_item;
            esel <= 2'd0;
            tsel <= 2'd0;
            srch <= '0;
            full <= 1'b0;
            if (q_item.op == OP_START) begin
              edge_count  <= '0;
              next_vertex <= ivc;
            end
          end
        end
        ST_SRCH_CMP: begin
          if (match) mid[esel] <= erd.mid;
          else srch <= srch + 1'b1;
        end
        ST_NEW: begin
          if (overflow) begin
            full      <= 1'b1;
            mid[esel] <= '0;
          end
        end
        ST_RD_HI: begin
          plo <= vrd_ok ? vrd : '0;
        end
        ST_SUM: begin
          mid[esel]   <= next_vertex[IDX_W-1:0];
          nmid        <= msum;
          next_vertex <= next_vertex + 1'b1;
          edge_count  <= edge_count + 1'b1;
        end
        ST_EMIT_V: begin
          if (out_free) begin
            out_data  <= '{out_kind: KIND_VERT, new_index: mid[esel],
                           new_x: nmid.x, new_y: nmid.y, new_z: nmid.z,
                           tri_first: '0, tri_second: '0, tri_third: '0,
                           store_full: full, last: 1'b0};
          end
        end
        ST_NEXT: begin
          esel <= esel + 2'd1;
          srch <= '0;
        end
        ST_EMIT_T: begin
          if (out_free) begin
            tsel      <= tsel + 2'd1;
            out_data  <= '{out_kind: KIND_TRI, new_index: '0,
                           new_x: '0, new_y: '0, new_z: '0,
                           tri_first: t_first, tri_second: t_second, tri_third: t_third,
                           store_full: full, last: (tsel == 2'd3)};
          end
        end
        default: begin
          srch <= srch;
        end
      endcase
    end
  end

endmodule

// ----- hdl/triangle_midpoint_subdivider.sv -----
// top level of the triangle midpoint subdivider
// depends on tms_pkg, tms_front and tms_back
//
// One level of midpoint triangle subdivision with shared edge midpoints.
// Input transactions (in_valid/in_ready, in_data) carry a command: load a
// vertex, subdivide a triangle, or clear the edge map and start a level.
// Result transactions (out_valid/out_ready, out_data) are midpoint vertex
// records followed by four child triangle records; last marks the final one.
// cfg_we/cfg_wdata set the input vertex count (first new midpoint index).
// A two-entry queue sits between the front end and the sequencer, so input
// is taken while the sequencer or the output register is busy.
// Load and start are each taken from the queue in the idle state. A triangle
// is handled edge by edge: the edge map is searched one entry at a time on
// its single read port (read, then compare); a new midpoint is summed and
// stored unless the store is full; then four triangle records are sent.
// Reset clears the edge count, the next vertex index, the queue and the
// output valid flag; the vertex store and edge map hold no reset value.
// When the receiver stalls, the output register holds its transaction and
// the sequencer waits, then the queue fills and in_ready drops.
module triangle_midpoint_subdivider
  import tms_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_EDGES    = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic [CNT_W-1:0] ivc;
  logic             q_valid;
  q_item_t          q_item;
  logic             pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) ivc <= IVC_RESET;
    else if (cfg_we) ivc <= cfg_wdata;
  end

  tms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  tms_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ivc       (ivc),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue popped while empty");

  a_last_is_tri: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (out_data.out_kind == KIND_TRI))
    else $error("last flag on a vertex record");

  a_vert_no_corners: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.out_kind == KIND_VERT) |->
      (out_data.tri_first == '0 && out_data.tri_second == '0 && out_data.tri_third == '0))
    else $error("vertex record carries corner indices");

endmodule
